// File: rtl/matrix_vector_multiply_top_defines.svh
// Assertion macros for the matrix-vector multiply block.
`ifndef MATRIX_VECTOR_MULTIPLY_TOP_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define MVM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mvm check failed: same-cycle implication");
`define MVM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mvm check failed: next-cycle implication");
`else
`define MVM_ASSERT_NOW(label, ante, cons)
`define MVM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiply block.
package mvm_pkg;

  localparam int VALUE_W     = 32;
  localparam int IDX_W       = 3;
  localparam int DIM_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int FIELD_LIMIT = 8;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int ACC_W       = PROD_W + IDX_W;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam logic OP_MATRIX = 1'b0;
  localparam logic OP_VECTOR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

endpackage

// File: rtl/matrix_vector_multiply_top.sv
// Matrix-vector multiply over signed Q16.16, one shared multiply-accumulate unit.
// Load items (matrix entries and vector elements) are taken one per cycle while
// busy is low. A vector item with last_element set starts a product: busy rises
// and the block steps one multiply-accumulate per cycle over rows x columns
// through a four-stage read/multiply/accumulate/clamp pipeline. Busy stays high
// while that pipeline drains, through the last row's result_strobe, and no new
// item is taken until busy falls. Results come out one per row, in
// row order, each on a single-cycle result_strobe; the receiver must take them as
// they appear. Matrix entries never written since reset read as zero through
// per-entry valid bits, so no clearing pass is needed. Configuration writes are
// always ready and must only be issued while busy is low.
`include "matrix_vector_multiply_top_defines.svh"

module matrix_vector_multiply_top #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op,
  input  logic [mvm_pkg::IDX_W-1:0]           row_index,
  input  logic [mvm_pkg::IDX_W-1:0]           col_index,
  input  logic signed [mvm_pkg::VALUE_W-1:0]  value,
  input  logic                                last_element,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mvm_pkg::DIM_W-1:0]           cfg_data,
  output logic                                result_strobe,
  output logic [mvm_pkg::IDX_W-1:0]           result_row,
  output logic signed [mvm_pkg::VALUE_W-1:0]  product_value,
  output logic                                last_of_run,
  output logic                                saturated
);
  import mvm_pkg::*;

  localparam int DIM_LIMIT = (MAX_DIM < FIELD_LIMIT) ? MAX_DIM : FIELD_LIMIT;
  localparam int VW        = $clog2(DIM_LIMIT);
  localparam int MAT_DEPTH = DIM_LIMIT * DIM_LIMIT;
  localparam int AW        = $clog2(MAT_DEPTH);

  state_t state, state_next;

  logic [DIM_W-1:0] rows_reg, cols_reg;
  logic [DIM_W-1:0] rows_eff, cols_eff;

  logic [IDX_W-1:0] row_cnt, row_cnt_next;
  logic [IDX_W-1:0] col_cnt, col_cnt_next;
  logic             issue;
  logic             col_last, row_last;

  logic             accept;
  logic             row_ok, col_ok;
  logic             mat_we, vec_we;
  logic [AW-1:0]    wr_addr, rd_addr;

  logic signed [VALUE_W-1:0] mat_mem [MAT_DEPTH];
  logic [MAT_DEPTH-1:0]      mat_vld;
  logic signed [VALUE_W-1:0] vec [DIM_LIMIT];

  logic                      s1_valid, s1_first, s1_last;
  logic [IDX_W-1:0]          s1_row;
  logic signed [VALUE_W-1:0] s1_mat, s1_vec;
  logic                      s1_mvld;
  logic signed [VALUE_W-1:0] mat_sel;
  logic signed [PROD_W-1:0]  mul;

  logic                      s2_valid, s2_first, s2_last;
  logic [IDX_W-1:0]          s2_row;
  logic signed [PROD_W-1:0]  s2_prod;

  logic signed [ACC_W-1:0]   acc;
  logic                      s3_done;
  logic [IDX_W-1:0]          s3_row;

  logic signed [ACC_W-1:0]   shifted;
  logic                      clamp;
  logic                      at_limit;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  // effective sizes: zero reads as one, oversize clamps to the store limit
  always_comb begin
    rows_eff = rows_reg;
    if (rows_reg == '0) begin
      rows_eff = DIM_W'(1);
    end else if (rows_reg > DIM_W'(DIM_LIMIT)) begin
      rows_eff = DIM_W'(DIM_LIMIT);
    end
    cols_eff = cols_reg;
    if (cols_reg == '0) begin
      cols_eff = DIM_W'(1);
    end else if (cols_reg > DIM_W'(DIM_LIMIT)) begin
      cols_eff = DIM_W'(DIM_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_reg <= DIM_RESET;
      cols_reg <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS: rows_reg <= cfg_data;
        REG_COLS: cols_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // load path
  assign row_ok  = (DIM_W'(row_index) < rows_eff);
  assign col_ok  = (DIM_W'(col_index) < cols_eff);
  assign mat_we  = accept && (op == OP_MATRIX) && row_ok && col_ok;
  assign vec_we  = accept && (op == OP_VECTOR) && col_ok;
  assign wr_addr = AW'(row_index) * AW'(DIM_LIMIT) + AW'(col_index);
  assign rd_addr = AW'(row_cnt) * AW'(DIM_LIMIT) + AW'(col_cnt);

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[wr_addr] <= value;
    end
    s1_mat <= mat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_vld <= '0;
    end else if (mat_we) begin
      mat_vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIM_LIMIT; i++) begin
        vec[i] <= '0;
      end
    end else if (vec_we) begin
      vec[col_index[VW-1:0]] <= value;
    end
  end

  // sequencer
  assign col_last = (DIM_W'(col_cnt) + DIM_W'(1) == cols_eff);
  assign row_last = (DIM_W'(row_cnt) + DIM_W'(1) == rows_eff);

  always_comb begin
    state_next   = state;
    row_cnt_next = row_cnt;
    col_cnt_next = col_cnt;
    issue        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && (op == OP_VECTOR) && last_element) begin
          state_next   = ST_RUN;
          row_cnt_next = '0;
          col_cnt_next = '0;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (col_last) begin
          col_cnt_next = '0;
          if (row_last) begin
            state_next = ST_DRAIN;
          end else begin
            row_cnt_next = row_cnt + IDX_W'(1);
          end
        end else begin
          col_cnt_next = col_cnt + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!s1_valid && !s2_valid && !s3_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      row_cnt <= '0;
      col_cnt <= '0;
    end else begin
      state   <= state_next;
      row_cnt <= row_cnt_next;
      col_cnt <= col_cnt_next;
    end
  end

  // stage 1: operand read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
    s1_first <= (col_cnt == '0);
    s1_last  <= col_last;
    s1_row   <= row_cnt;
    s1_mvld  <= mat_vld[rd_addr];
    s1_vec   <= vec[col_cnt[VW-1:0]];
  end

  // stage 2: multiply
  assign mat_sel = s1_mvld ? s1_mat : '0;
  assign mul     = PROD_W'(mat_sel) * PROD_W'(s1_vec);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_row   <= s1_row;
    s2_prod  <= mul;
  end

  // stage 3: accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_done <= 1'b0;
    end else begin
      s3_done <= s2_valid && s2_last;
    end
    if (s2_valid) begin
      acc    <= (s2_first ? '0 : acc) + ACC_W'(s2_prod);
      s3_row <= s2_row;
    end
  end

  // stage 4: floor shift and clamp
  assign shifted = acc >>> FRAC_BITS;
  assign clamp   = !((&shifted[ACC_W-1:VALUE_W-1]) || !(|shifted[ACC_W-1:VALUE_W-1]));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= s3_done;
    end
    if (s3_done) begin
      result_row    <= s3_row;
      last_of_run   <= (DIM_W'(s3_row) + DIM_W'(1) == rows_eff);
      saturated     <= clamp;
      product_value <= clamp ? (shifted[ACC_W-1] ? VALUE_MIN : VALUE_MAX)
                             : shifted[VALUE_W-1:0];
    end
  end

  assign at_limit = (product_value == VALUE_MAX) || (product_value == VALUE_MIN);

  `MVM_ASSERT_NOW(a_strobe_in_busy, result_strobe, busy)
  `MVM_ASSERT_NEXT(a_start_runs, accept && (op == OP_VECTOR) && last_element, busy)
  `MVM_ASSERT_NOW(a_row_in_range, result_strobe, DIM_W'(result_row) < rows_eff)
  `MVM_ASSERT_NOW(a_sat_clamped, result_strobe && saturated, at_limit)
  `MVM_ASSERT_NEXT(a_run_ends, result_strobe && last_of_run, !result_strobe)

endmodule

// File: tb/sv/mvm_product_checker.sv
// Checker for the matrix-vector multiply block: predicts each product and compares results.
`timescale 1ns / 100ps

module mvm_product_checker #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                op,
  input  logic [mvm_pkg::IDX_W-1:0]           row_index,
  input  logic [mvm_pkg::IDX_W-1:0]           col_index,
  input  logic signed [mvm_pkg::VALUE_W-1:0]  value,
  input  logic                                last_element,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mvm_pkg::DIM_W-1:0]           cfg_data,
  input  logic                                result_strobe,
  input  logic [mvm_pkg::IDX_W-1:0]           result_row,
  input  logic signed [mvm_pkg::VALUE_W-1:0]  product_value,
  input  logic                                last_of_run,
  input  logic                                saturated,
  output int                                  fail_count,
  output int                                  pending_results
);
  import mvm_pkg::*;

  localparam int DIM_LIMIT = (MAX_DIM < FIELD_LIMIT) ? MAX_DIM : FIELD_LIMIT;
  localparam int SUM_W     = PROD_W + 8;
  localparam logic signed [SUM_W-1:0] SUM_HI = VALUE_MAX;
  localparam logic signed [SUM_W-1:0] SUM_LO = VALUE_MIN;

  typedef struct {
    logic [IDX_W-1:0]          row;
    logic signed [VALUE_W-1:0] val;
    logic                      last;
    logic                      sat;
  } row_result_t;

  logic signed [VALUE_W-1:0] matrix_entries [MAX_DIM][MAX_DIM];
  logic signed [VALUE_W-1:0] vector_elems [MAX_DIM];
  logic [DIM_W-1:0]          rows_reg;
  logic [DIM_W-1:0]          cols_reg;
  row_result_t               expected_rows [$];
  int                        mismatches = 0;

  function automatic int eff_dim(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM_LIMIT) return DIM_LIMIT;
    return int'(d);
  endfunction

  task automatic predict_products(int rows, int cols);
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] lhs;
    logic signed [SUM_W-1:0] rhs;
    row_result_t             res;
    for (int i = 0; i < rows; i++) begin
      acc = '0;
      for (int k = 0; k < cols; k++) begin
        lhs = matrix_entries[i][k];
        rhs = vector_elems[k];
        acc += lhs * rhs;
      end
      acc = acc >>> FRAC_BITS;
      res.row  = IDX_W'(i);
      res.last = (i == rows - 1);
      res.sat  = 1'b1;
      if (acc > SUM_HI) begin
        res.val = VALUE_MAX;
      end else if (acc < SUM_LO) begin
        res.val = VALUE_MIN;
      end else begin
        res.sat = 1'b0;
        res.val = acc[VALUE_W-1:0];
      end
      expected_rows.push_back(res);
    end
  endtask

  task automatic take_item();
    int rows;
    int cols;
    rows = eff_dim(rows_reg);
    cols = eff_dim(cols_reg);
    if (op == OP_MATRIX) begin
      if (row_index < rows && col_index < cols) matrix_entries[row_index][col_index] = value;
    end else begin
      if (col_index < cols) vector_elems[col_index] = value;
      if (last_element) predict_products(rows, cols);
    end
  endtask

  always @(posedge clk) begin
    row_result_t want;
    if (rst) begin
      rows_reg = DIM_RESET;
      cols_reg = DIM_RESET;
      for (int i = 0; i < MAX_DIM; i++) begin
        vector_elems[i] = '0;
        for (int k = 0; k < MAX_DIM; k++) matrix_entries[i][k] = '0;
      end
      expected_rows.delete();
    end else begin
      if (result_strobe) begin
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result row %0d value %0d", $time, result_row,
                     product_value);
        end else begin
          want = expected_rows.pop_front();
          if (result_row !== want.row || product_value !== want.val ||
              last_of_run !== want.last || saturated !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch exp/act row %0d/%0d value %0d/%0d ",
                        "last %0b/%0b sat %0b/%0b"}, $time, want.row, result_row,
                       want.val, product_value, want.last, last_of_run,
                       want.sat, saturated);
          end
        end
      end
      if (start && !busy) take_item();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS: rows_reg = cfg_data;
          REG_COLS: cols_reg = cfg_data;
          default: ;
        endcase
      end
    end
    fail_count      <= mismatches;
    pending_results <= expected_rows.size();
  end

endmodule

// File: tb/sv/matrix_vector_multiply_top_tb.sv
// Top of the matrix-vector multiply testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module matrix_vector_multiply_top_tb;
  import mvm_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      op = OP_MATRIX;
  logic [IDX_W-1:0]          row_index = '0;
  logic [IDX_W-1:0]          col_index = '0;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      last_element = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_ROWS;
  logic [DIM_W-1:0]          cfg_data = '0;
  logic                      result_strobe;
  logic [IDX_W-1:0]          result_row;
  logic signed [VALUE_W-1:0] product_value;
  logic                      last_of_run;
  logic                      saturated;
  int                        fail_count;
  int                        pending_results;

  int rows_now = 8;
  int cols_now = 8;
  int idle_pct [4] = '{0, 53, 0, 35};

  always #5 clk = ~clk;

  matrix_vector_multiply_top u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .row_index     (row_index),
    .col_index     (col_index),
    .value         (value),
    .last_element  (last_element),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .result_row    (result_row),
    .product_value (product_value),
    .last_of_run   (last_of_run),
    .saturated     (saturated)
  );

  mvm_product_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .row_index       (row_index),
    .col_index       (col_index),
    .value           (value),
    .last_element    (last_element),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .result_strobe   (result_strobe),
    .result_row      (result_row),
    .product_value   (product_value),
    .last_of_run     (last_of_run),
    .saturated       (saturated),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return VALUE_W'($urandom_range(32'h0003_ffff)) - 32'h0002_0000;
      2: return $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
      default: return (32'($urandom_range(15)) - 32'd8) << FRAC_BITS;
    endcase
  endfunction

  task automatic send_item(logic op_i, int r, int c, logic signed [VALUE_W-1:0] v,
                           logic last_i, int pct);
    start        <= 1'b1;
    op           <= op_i;
    row_index    <= IDX_W'(r);
    col_index    <= IDX_W'(c);
    value        <= v;
    last_element <= last_i;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  // both dimension registers, back to back; call only while drained
  task automatic write_dims(logic [DIM_W-1:0] rows_cfg, logic [DIM_W-1:0] cols_cfg);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_data  <= rows_cfg;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_COLS;
    cfg_data  <= cols_cfg;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rows_now = (rows_cfg == 0) ? 1 : (rows_cfg > 8) ? 8 : int'(rows_cfg);
    cols_now = (cols_cfg == 0) ? 1 : (cols_cfg > 8) ? 8 : int'(cols_cfg);
  endtask

  // mostly in-range loads closed by a last vector item, some stray indices and early lasts
  task automatic run_bursts(int n_items, int pct);
    int sent;
    int loads;
    logic op_i;
    logic last_i;
    int r;
    int c;
    sent = 0;
    while (sent < n_items) begin
      loads = $urandom_range(1, 2 * cols_now + 2);
      for (int k = 0; k < loads; k++) begin
        op_i = $urandom_range(1) ? OP_VECTOR : OP_MATRIX;
        last_i = (op_i == OP_MATRIX) ? 1'($urandom_range(1)) : ($urandom_range(9) == 0);
        if ($urandom_range(7) == 0) begin
          r = $urandom_range(7);
          c = $urandom_range(7);
        end else begin
          r = (op_i == OP_MATRIX) ? $urandom_range(rows_now - 1) : $urandom_range(7);
          c = $urandom_range(cols_now - 1);
        end
        send_item(op_i, r, c, pick_value(), last_i, pct);
        sent++;
      end
      send_item(OP_VECTOR, $urandom_range(7), $urandom_range(cols_now - 1), pick_value(),
                1'b1, pct);
      sent++;
      if ($urandom_range(5) == 0) wait_drained();
    end
  endtask

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // product over cleared stores
    send_item(OP_VECTOR, 0, 0, '0, 1'b1, 0);
    send_item(OP_MATRIX, 0, 0, VALUE_MIN, 1'b0, 0);
    send_item(OP_MATRIX, 1, 0, VALUE_MAX, 1'b0, 0);
    // last mark on a matrix item has no effect
    send_item(OP_MATRIX, 7, 7, 32'sh0001_0000, 1'b1, 0);
    send_item(OP_MATRIX, 2, 1, 32'sh0001_8000, 1'b0, 0);
    send_item(OP_MATRIX, 3, 2, 32'sh0000_0001, 1'b0, 0);
    send_item(OP_VECTOR, 7, 7, 32'sh0002_0000, 1'b0, 0);
    send_item(OP_VECTOR, 0, 1, -32'sh0001_0000, 1'b0, 0);
    send_item(OP_VECTOR, 0, 2, -32'sh0000_0001, 1'b0, 0);
    send_item(OP_VECTOR, 0, 0, VALUE_MIN, 1'b1, 0);
    wait_drained();

    // zero rows read as one, oversized columns clamp
    write_dims(4'd0, 4'd15);
    send_item(OP_VECTOR, 5, 3, VALUE_MAX, 1'b1, 0);
    wait_drained();

    // out-of-range writes dropped; product still runs on a dropped vector write
    write_dims(4'd3, 4'd2);
    send_item(OP_MATRIX, 5, 1, VALUE_MAX, 1'b0, 0);
    send_item(OP_MATRIX, 1, 4, VALUE_MAX, 1'b0, 0);
    send_item(OP_MATRIX, 2, 1, -32'sh0001_0000, 1'b0, 0);
    send_item(OP_VECTOR, 0, 6, VALUE_MAX, 1'b1, 0);
    wait_drained();

    write_dims(4'd8, 4'd1);
    send_item(OP_VECTOR, 0, 0, 32'sh0003_0000, 1'b1, 0);
    wait_drained();

    // stale elements reused at full size
    write_dims(4'd8, 4'd8);
    send_item(OP_VECTOR, 2, 5, 32'sh0000_8000, 1'b1, 0);

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      case (p)
        0: write_dims(4'd15, 4'd8);
        1: write_dims(4'd1, 4'd0);
        default: write_dims(4'($urandom_range(15)), 4'($urandom_range(15)));
      endcase
      run_bursts(20, idle_pct[p]);
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
